@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Each macro takes a label, the clock, the reset
// and two boolean expressions: an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sia_pkg.sv @@
package sia_pkg;

   typedef enum logic [3:0] {
      FUNC_ADD = 4'd0,
      FUNC_SUB = 4'd1,
      FUNC_MUL = 4'd2,
      FUNC_DIV = 4'd3,
      FUNC_REM = 4'd4,
      FUNC_SHL = 4'd5,
      FUNC_SAR = 4'd6,
      FUNC_AND = 4'd7,
      FUNC_OR  = 4'd8,
      FUNC_XOR = 4'd9,
      FUNC_NOT = 4'd10
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_DIV0  = 2'd1,
      STATUS_SHIFT = 2'd2,
      STATUS_OVF   = 2'd3
   } status_type;

   // Control that travels with each item down the cell chain.
   typedef struct packed {
      logic       valid;
      func_type   op;
      status_type status;
      logic       neg_q;
      logic       neg_r;
   } ctrl_type;

   localparam ctrl_type CTRL_IDLE = '{valid: 1'b0, op: FUNC_ADD, status: STATUS_OK,
                                      neg_q: 1'b0, neg_r: 1'b0};

endpackage

@@ rtl/signed_integer_alu_unit.sv @@
// Channel   | Direction | Ports                          | Contents
// ----------+-----------+--------------------------------+-------------------------------
// request   | in        | req_tvalid/tready/tdata/tuser  | operands in tdata, func in tuser
// response  | out       | rsp_tvalid/tready/tdata/tuser  | result in tdata, status in tuser
//
// One transfer is taken every clock cycle while req_tready is high; each result reaches
// the port through the operand stage, which loads at the accepting edge, then DATA_WIDTH
// cells that each retire one quotient or multiplier bit, then the output register.
// Reset is synchronous and active high; it clears the valid bits of every stage.
// A stalled response is held in the output register while one more item lands in a skid
// register; only then is req_tready dropped, and the whole chain holds until it drains.

`include "assert_macros.svh"

module signed_integer_alu_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // tdata, from bit 0: operand_a, operand_b, zero fill to whole bytes
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       req_tdata,
   // tuser: func
   input  logic [3:0]                              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // tdata, from bit 0: result, zero fill to whole bytes
   output logic [((DATA_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // tuser: status
   output logic [1:0]                              rsp_tuser
);

   localparam int RSP_W = ((DATA_WIDTH + 7) / 8) * 8;

   // Stage signals of the chain: index 0 is the operand stage, index i + 1 is cell i.
   sia_pkg::ctrl_type     ctrl_chain [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_chain  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dq_chain   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] opnd_chain [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] side_chain [0:DATA_WIDTH];

   logic                  advance;
   logic [DATA_WIDTH-1:0] result;
   logic                  chain_done, rsp_stall, rsp_err;

   // The chain moves only while the skid register is empty, so ready is registered
   // state and never a combinational path from rsp_tready.
   assign req_tready = advance;

   sia_front #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .in_valid(req_tvalid),
      .in_func (req_tuser),
      .in_a    (req_tdata[DATA_WIDTH-1:0]),
      .in_b    (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .dn_ctrl (ctrl_chain[0]),
      .dn_rem  (rem_chain[0]),
      .dn_dq   (dq_chain[0]),
      .dn_opnd (opnd_chain[0]),
      .dn_side (side_chain[0])
   );

   // Every item walks the full chain, whatever its operation, so results leave in order.
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : gen_cell
      sia_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (advance),
         .up_ctrl(ctrl_chain[i]),
         .up_rem (rem_chain[i]),
         .up_dq  (dq_chain[i]),
         .up_opnd(opnd_chain[i]),
         .up_side(side_chain[i]),
         .dn_ctrl(ctrl_chain[i+1]),
         .dn_rem (rem_chain[i+1]),
         .dn_dq  (dq_chain[i+1]),
         .dn_opnd(opnd_chain[i+1]),
         .dn_side(side_chain[i+1])
      );
   end

   // Sign correction of quotient and remainder, final selection, output and skid registers.
   sia_back #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .up_ctrl   (ctrl_chain[DATA_WIDTH]),
      .up_rem    (rem_chain[DATA_WIDTH]),
      .up_dq     (dq_chain[DATA_WIDTH]),
      .up_side   (side_chain[DATA_WIDTH]),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_result(result),
      .out_status(rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(result);

   // Short names for the conditions that the checks below refer to.
   assign chain_done = ctrl_chain[DATA_WIDTH].valid;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_err    = rsp_tvalid && (rsp_tuser == sia_pkg::STATUS_DIV0 ||
                                      rsp_tuser == sia_pkg::STATUS_SHIFT);

   // A frozen chain always has a response waiting at the port.
   `ASSERT_SAME(a_hold_has_rsp, clock, reset, !advance, rsp_tvalid)
   // A finished item arriving at a stalled port must park in the skid register.
   `ASSERT_NEXT(a_skid_fill, clock, reset, advance && chain_done && rsp_stall, !advance)
   // A taken response lets the parked item move up and frees the chain.
   `ASSERT_NEXT(a_skid_drain, clock, reset, !advance && rsp_tready, advance && rsp_tvalid)
   // Divide by zero and a bad shift amount both give a zero result.
   `ASSERT_SAME(a_err_zero, clock, reset, rsp_err, result == '0)

endmodule

@@ rtl/sia_front.sv @@
module sia_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [3:0]             in_func,
   input  logic [DATA_WIDTH-1:0]  in_a,
   input  logic [DATA_WIDTH-1:0]  in_b,
   output sia_pkg::ctrl_type      dn_ctrl,
   output logic [DATA_WIDTH-1:0]  dn_rem,
   output logic [DATA_WIDTH-1:0]  dn_dq,
   output logic [DATA_WIDTH-1:0]  dn_opnd,
   output logic [DATA_WIDTH-1:0]  dn_side
);

   localparam int SH_W = $clog2(DATA_WIDTH);
   localparam logic [DATA_WIDTH-1:0] WIDTH_VAL = DATA_WIDTH'(DATA_WIDTH);
   localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   sia_pkg::ctrl_type     ctrl_ff, ctrl_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dq_ff, dq_in;
   logic [DATA_WIDTH-1:0] opnd_ff, opnd_in;
   logic [DATA_WIDTH-1:0] side_ff, side_in;

   logic                  a_neg, b_neg, shift_bad;
   logic [DATA_WIDTH-1:0] mag_a, mag_b;
   logic [SH_W-1:0]       sh_amt;
   sia_pkg::func_type     op;

   always_comb begin
      op        = sia_pkg::func_type'(in_func);
      a_neg     = in_a[DATA_WIDTH-1];
      b_neg     = in_b[DATA_WIDTH-1];
      mag_a     = a_neg ? (~in_a + 1'b1) : in_a;
      mag_b     = b_neg ? (~in_b + 1'b1) : in_b;
      sh_amt    = in_b[SH_W-1:0];
      shift_bad = b_neg || !(in_b < WIDTH_VAL);

      ctrl_in        = sia_pkg::CTRL_IDLE;
      ctrl_in.valid  = in_valid;
      ctrl_in.op     = op;
      ctrl_in.neg_q  = a_neg ^ b_neg;
      ctrl_in.neg_r  = a_neg;
      rem_in         = '0;
      dq_in          = mag_a;
      opnd_in        = mag_b;
      side_in        = '0;

      case (op)
         sia_pkg::FUNC_ADD: side_in = in_a + in_b;
         sia_pkg::FUNC_SUB: side_in = in_a - in_b;
         sia_pkg::FUNC_MUL: begin
            dq_in   = in_b;
            opnd_in = in_a;
         end
         sia_pkg::FUNC_DIV, sia_pkg::FUNC_REM: begin
            if (in_b == '0) begin
               ctrl_in.status = sia_pkg::STATUS_DIV0;
            end else if (in_a == MOST_NEG && in_b == '1) begin
               ctrl_in.status = sia_pkg::STATUS_OVF;
            end
         end
         sia_pkg::FUNC_SHL: begin
            if (shift_bad) begin
               ctrl_in.status = sia_pkg::STATUS_SHIFT;
            end else begin
               side_in = in_a << sh_amt;
            end
         end
         sia_pkg::FUNC_SAR: begin
            if (shift_bad) begin
               ctrl_in.status = sia_pkg::STATUS_SHIFT;
            end else begin
               side_in = $unsigned($signed(in_a) >>> sh_amt);
            end
         end
         sia_pkg::FUNC_AND: side_in = in_a & in_b;
         sia_pkg::FUNC_OR:  side_in = in_a | in_b;
         sia_pkg::FUNC_XOR: side_in = in_a ^ in_b;
         sia_pkg::FUNC_NOT: side_in = ~in_a;
         default:           side_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= sia_pkg::CTRL_IDLE;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
         opnd_ff <= opnd_in;
         side_ff <= side_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_rem  = rem_ff;
   assign dn_dq   = dq_ff;
   assign dn_opnd = opnd_ff;
   assign dn_side = side_ff;

endmodule

@@ rtl/sia_cell.sv @@
module sia_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  sia_pkg::ctrl_type      up_ctrl,
   input  logic [DATA_WIDTH-1:0]  up_rem,
   input  logic [DATA_WIDTH-1:0]  up_dq,
   input  logic [DATA_WIDTH-1:0]  up_opnd,
   input  logic [DATA_WIDTH-1:0]  up_side,
   output sia_pkg::ctrl_type      dn_ctrl,
   output logic [DATA_WIDTH-1:0]  dn_rem,
   output logic [DATA_WIDTH-1:0]  dn_dq,
   output logic [DATA_WIDTH-1:0]  dn_opnd,
   output logic [DATA_WIDTH-1:0]  dn_side
);

   // One bit step per cell. Division: restoring step, partial remainder in rem and
   // dividend bits shifting out of dq while quotient bits shift in. Multiply: shift-add,
   // accumulator in rem, multiplier bits taken from the top of dq.

   sia_pkg::ctrl_type     ctrl_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dq_ff, dq_in;
   logic [DATA_WIDTH-1:0] opnd_ff;
   logic [DATA_WIDTH-1:0] side_ff;

   logic                  is_mul, take;
   logic [DATA_WIDTH:0]   x_val, y_val;
   logic [DATA_WIDTH+1:0] sum_val;

   always_comb begin
      is_mul = (up_ctrl.op == sia_pkg::FUNC_MUL);
      if (is_mul) begin
         x_val = {1'b0, up_rem[DATA_WIDTH-2:0], 1'b0};
         y_val = up_dq[DATA_WIDTH-1] ? {1'b0, up_opnd} : '0;
      end else begin
         x_val = {up_rem, up_dq[DATA_WIDTH-1]};
         y_val = {1'b0, up_opnd};
      end
      // Shared adder: add for multiply, subtract for division.
      sum_val = {1'b0, x_val} + ({(DATA_WIDTH+2){!is_mul}} ^ {1'b0, y_val})
              + (DATA_WIDTH+2)'(!is_mul);
      take    = !sum_val[DATA_WIDTH+1];
      if (is_mul) begin
         rem_in = sum_val[DATA_WIDTH-1:0];
         dq_in  = {up_dq[DATA_WIDTH-2:0], 1'b0};
      end else begin
         rem_in = take ? sum_val[DATA_WIDTH-1:0] : x_val[DATA_WIDTH-1:0];
         dq_in  = {up_dq[DATA_WIDTH-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= sia_pkg::CTRL_IDLE;
      end else if (en) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
         opnd_ff <= up_opnd;
         side_ff <= up_side;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_rem  = rem_ff;
   assign dn_dq   = dq_ff;
   assign dn_opnd = opnd_ff;
   assign dn_side = side_ff;

endmodule

@@ rtl/sia_back.sv @@
module sia_back #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sia_pkg::ctrl_type      up_ctrl,
   input  logic [DATA_WIDTH-1:0]  up_rem,
   input  logic [DATA_WIDTH-1:0]  up_dq,
   input  logic [DATA_WIDTH-1:0]  up_side,
   output logic                   advance,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [DATA_WIDTH-1:0]  out_result,
   output logic [1:0]             out_status
);

   logic                  out_vld_ff, out_vld_in;
   logic [DATA_WIDTH-1:0] out_res_ff, out_res_in;
   logic [1:0]            out_st_ff, out_st_in;
   logic                  skid_vld_ff, skid_vld_in;
   logic [DATA_WIDTH-1:0] skid_res_ff, skid_res_in;
   logic [1:0]            skid_st_ff, skid_st_in;

   logic                  new_item, div0;
   logic [DATA_WIDTH-1:0] fin_res;

   always_comb begin
      div0 = (up_ctrl.status == sia_pkg::STATUS_DIV0);
      case (up_ctrl.op)
         sia_pkg::FUNC_MUL: fin_res = up_rem;
         sia_pkg::FUNC_DIV: begin
            if (div0) begin
               fin_res = '0;
            end else begin
               fin_res = up_ctrl.neg_q ? (~up_dq + 1'b1) : up_dq;
            end
         end
         sia_pkg::FUNC_REM: begin
            if (div0) begin
               fin_res = '0;
            end else begin
               fin_res = up_ctrl.neg_r ? (~up_rem + 1'b1) : up_rem;
            end
         end
         default: fin_res = up_side;
      endcase

      advance     = !skid_vld_ff;
      new_item    = advance && up_ctrl.valid;
      out_vld_in  = out_vld_ff;
      out_res_in  = out_res_ff;
      out_st_in   = out_st_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      skid_st_in  = skid_st_ff;

      if (skid_vld_ff) begin
         if (out_ready) begin
            out_res_in  = skid_res_ff;
            out_st_in   = skid_st_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || out_ready) begin
         out_vld_in = new_item;
         out_res_in = fin_res;
         out_st_in  = up_ctrl.status;
      end else if (new_item) begin
         skid_vld_in = 1'b1;
         skid_res_in = fin_res;
         skid_st_in  = up_ctrl.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      out_st_ff   <= out_st_in;
      skid_res_ff <= skid_res_in;
      skid_st_ff  <= skid_st_in;
   end

   assign out_valid  = out_vld_ff;
   assign out_result = out_res_ff;
   assign out_status = out_st_ff;

endmodule
